### src/axis_tick_interval_picker_unit_defines.svh
// assertion macros for the tick interval picker
`ifndef AXIS_TICK_INTERVAL_PICKER_UNIT_DEFINES_SVH
`define AXIS_TICK_INTERVAL_PICKER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define ATIP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("atip assertion failed");
`define ATIP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("atip assertion failed");
`else
`define ATIP_ASSERT(lbl, clk, rst, prop)
`define ATIP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### src/atip_pkg.sv
`default_nettype none
package atip_pkg;

   localparam int unsigned PowTopIdx = 19;
   localparam logic [15:0] FallbackCount = 16'd10;
   localparam logic [15:0] CountReset = 16'd10;
   localparam logic [15:0] WidthReset = 16'd1024;

   localparam logic [7:0] RegLineCount = 8'd0;
   localparam logic [7:0] RegViewWidth = 8'd1;

   localparam logic [1:0] UnitNs = 2'd0;
   localparam logic [1:0] UnitUs = 2'd1;
   localparam logic [1:0] UnitMs = 2'd2;
   localparam logic [1:0] UnitS  = 2'd3;

   localparam logic [63:0] NsPerS  = 64'd1000000000;
   localparam logic [63:0] NsPerMs = 64'd1000000;
   localparam logic [63:0] NsPerUs = 64'd1000;

   typedef struct packed {
      logic [63:0] window_start;
      logic [63:0] window_end;
   } req_type;

   typedef struct packed {
      logic [63:0] first_line;
      logic [63:0] line_spacing;
      logic [31:0] line_total;
      logic [1:0]  unit_code;
      logic [29:0] unit_multiplier;
      logic        degenerate;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [63:0] remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WANT_WAIT,
      ST_SCAN,
      ST_BASE_WAIT,
      ST_CHECK,
      ST_START_WAIT,
      ST_END_WAIT,
      ST_SPAN_WAIT,
      ST_OUT
   } state_type;

   // powers of ten up to 10^19
   function automatic logic [63:0] pow10(input logic [4:0] k);
      logic [63:0] r;
      unique case (k)
         5'd0:  r = 64'd1;
         5'd1:  r = 64'd10;
         5'd2:  r = 64'd100;
         5'd3:  r = 64'd1000;
         5'd4:  r = 64'd10000;
         5'd5:  r = 64'd100000;
         5'd6:  r = 64'd1000000;
         5'd7:  r = 64'd10000000;
         5'd8:  r = 64'd100000000;
         5'd9:  r = 64'd1000000000;
         5'd10: r = 64'd10000000000;
         5'd11: r = 64'd100000000000;
         5'd12: r = 64'd1000000000000;
         5'd13: r = 64'd10000000000000;
         5'd14: r = 64'd100000000000000;
         5'd15: r = 64'd1000000000000000;
         5'd16: r = 64'd10000000000000000;
         5'd17: r = 64'd100000000000000000;
         5'd18: r = 64'd1000000000000000000;
         5'd19: r = 64'd10000000000000000000;
         default: r = 64'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### src/atip_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module atip_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire atip_pkg::div_req_type div_req,
   output atip_pkg::div_rsp_type      div_rsp
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] diff;

   // one shift and subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[63]};
      diff    = trial - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = 64'd0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[64]) begin
            rem_in = diff[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= 7'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
`default_nettype wire

### src/axis_tick_interval_picker_unit.sv
// sequence: up to five 64-bit divisions on the shared divider, with a power-of-ten
//   scan between the first and second division
// throughput: one word at a time; req_stall is high from acceptance until the
//   result is loaded into the output register
// reset: synchronous, clears control state; line count reads 10, view width 1024
`default_nettype none
`include "axis_tick_interval_picker_unit_defines.svh"
module axis_tick_interval_picker_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire atip_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output atip_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [7:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   atip_pkg::state_type state_ff, state_in;
   logic [15:0] count_ff, width_ff;
   logic [63:0] start_ff, start_in;
   logic [63:0] end_ff, end_in;
   logic [63:0] wanted_ff, wanted_in;
   logic [4:0]  k_ff, k_in;
   logic [63:0] spacing_ff, spacing_in;
   logic [63:0] first_ff, first_in;
   logic [31:0] total_ff, total_in;
   logic        deg_ff, deg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   atip_pkg::rsp_type rsp_ff, rsp_in;

   atip_pkg::div_req_type div_req;
   atip_pkg::div_rsp_type div_rsp;

   logic [15:0] eff_count;
   logic [63:0] base;
   logic [63:0] low;
   logic [63:0] up_diff;
   logic [64:0] next_first;
   logic [63:0] last;
   logic        load_out;

   atip_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= atip_pkg::CountReset;
         width_ff <= atip_pkg::WidthReset;
      end else if (csr_we) begin
         unique case (csr_index)
            atip_pkg::RegLineCount: count_ff <= csr_wdata;
            atip_pkg::RegViewWidth: width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign eff_count = (count_ff == 16'd0 || count_ff > width_ff) ?
                      atip_pkg::FallbackCount : count_ff;
   assign base      = atip_pkg::pow10(k_ff);
   assign low       = wanted_ff - div_rsp.remainder;
   assign up_diff   = base - div_rsp.remainder;
   assign next_first = {1'b0, start_ff} - {1'b0, div_rsp.remainder} + {1'b0, spacing_ff};
   assign last      = end_ff - div_rsp.remainder;
   assign load_out  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      wanted_in  = wanted_ff;
      k_in       = k_ff;
      spacing_in = spacing_ff;
      first_in   = first_ff;
      total_in   = total_ff;
      deg_in     = deg_ff;
      div_req    = '0;
      rsp_in     = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         atip_pkg::ST_IDLE: begin
            if (req_valid) begin
               start_in = req_data.window_start;
               end_in   = req_data.window_end;
               deg_in   = 1'b0;
               if (req_data.window_end < req_data.window_start) begin
                  deg_in   = 1'b1;
                  state_in = atip_pkg::ST_OUT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = req_data.window_end - req_data.window_start;
                  div_req.divisor  = {48'd0, eff_count};
                  state_in = atip_pkg::ST_WANT_WAIT;
               end
            end
         end
         atip_pkg::ST_WANT_WAIT: begin
            if (div_rsp.done) begin
               wanted_in = div_rsp.quotient;
               k_in      = 5'd0;
               state_in  = atip_pkg::ST_SCAN;
            end
         end
         atip_pkg::ST_SCAN: begin
            if (k_ff < 5'(atip_pkg::PowTopIdx) &&
                wanted_ff >= atip_pkg::pow10(k_ff + 5'd1)) begin
               k_in = k_ff + 5'd1;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = wanted_ff;
               div_req.divisor  = base;
               state_in = atip_pkg::ST_BASE_WAIT;
            end
         end
         atip_pkg::ST_BASE_WAIT: begin
            if (div_rsp.done) begin
               // round to nearest, ties down
               if (k_ff == 5'(atip_pkg::PowTopIdx) || div_rsp.remainder <= up_diff)
                  spacing_in = low;
               else
                  spacing_in = low + base;
               state_in = atip_pkg::ST_CHECK;
            end
         end
         atip_pkg::ST_CHECK: begin
            if (spacing_ff == 64'd0) begin
               deg_in   = 1'b1;
               state_in = atip_pkg::ST_OUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = start_ff;
               div_req.divisor  = spacing_ff;
               state_in = atip_pkg::ST_START_WAIT;
            end
         end
         atip_pkg::ST_START_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == 64'd0) begin
                  first_in = start_ff;
               end else begin
                  first_in = next_first[63:0];
               end
               if (div_rsp.remainder != 64'd0 && next_first[64]) begin
                  deg_in   = 1'b1;
                  state_in = atip_pkg::ST_OUT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = end_ff;
                  div_req.divisor  = spacing_ff;
                  state_in = atip_pkg::ST_END_WAIT;
               end
            end
         end
         atip_pkg::ST_END_WAIT: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = (last < first_ff) ? 64'd0 : last - first_ff;
               div_req.divisor  = spacing_ff;
               state_in = atip_pkg::ST_SPAN_WAIT;
            end
         end
         atip_pkg::ST_SPAN_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient >= 64'hFFFF_FFFF)
                  total_in = 32'hFFFF_FFFF;
               else
                  total_in = div_rsp.quotient[31:0] + 32'd1;
               state_in = atip_pkg::ST_OUT;
            end
         end
         atip_pkg::ST_OUT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               if (deg_ff) begin
                  rsp_in.degenerate = 1'b1;
               end else begin
                  rsp_in.first_line   = first_ff;
                  rsp_in.line_spacing = spacing_ff;
                  rsp_in.line_total   = total_ff;
                  if (spacing_ff >= atip_pkg::NsPerS) begin
                     rsp_in.unit_code       = atip_pkg::UnitS;
                     rsp_in.unit_multiplier = atip_pkg::NsPerS[29:0];
                  end else if (spacing_ff >= atip_pkg::NsPerMs) begin
                     rsp_in.unit_code       = atip_pkg::UnitMs;
                     rsp_in.unit_multiplier = atip_pkg::NsPerMs[29:0];
                  end else if (spacing_ff >= atip_pkg::NsPerUs) begin
                     rsp_in.unit_code       = atip_pkg::UnitUs;
                     rsp_in.unit_multiplier = atip_pkg::NsPerUs[29:0];
                  end else begin
                     rsp_in.unit_code       = atip_pkg::UnitNs;
                     rsp_in.unit_multiplier = 30'd1;
                  end
               end
               state_in = atip_pkg::ST_IDLE;
            end
         end
         default: state_in = atip_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= atip_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and output word registers
   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      end_ff     <= end_in;
      wanted_ff  <= wanted_in;
      k_ff       <= k_in;
      spacing_ff <= spacing_in;
      first_ff   <= first_in;
      total_ff   <= total_in;
      deg_ff     <= deg_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != atip_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ATIP_ASSERT(a_deg_zero, clock, reset, (rsp_valid_ff && rsp_ff.degenerate) |-> (rsp_ff.line_spacing == 64'd0 && rsp_ff.first_line == 64'd0))
   `ATIP_ASSERT(a_ok_nonzero, clock, reset, (rsp_valid_ff && !rsp_ff.degenerate) |-> (rsp_ff.line_spacing != 64'd0 && rsp_ff.line_total != 32'd0))
   `ATIP_ASSERT(a_done_waited, clock, reset, div_rsp.done |-> (state_ff == atip_pkg::ST_WANT_WAIT || state_ff == atip_pkg::ST_BASE_WAIT || state_ff == atip_pkg::ST_START_WAIT || state_ff == atip_pkg::ST_END_WAIT || state_ff == atip_pkg::ST_SPAN_WAIT))
   `ATIP_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (!rsp_valid_ff && state_ff == atip_pkg::ST_IDLE))

endmodule
`default_nettype wire
